// File: src/ycr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_pkg
// Shared types, widths and constants of the YCbCr to RGB pixel converter.
// ----------------------------------------------------------------------------
package ycr_pkg;

    localparam int SAMPLE_WIDTH = 16;          // raw sample container
    localparam int EXP_W        = 20;          // expanded sample, signed Q16
    localparam int COEF_W       = 17;          // matrix coefficient, unsigned Q16
    localparam int PROD_W       = EXP_W + COEF_W + 1;
    localparam int RND_W        = PROD_W - 16; // product rounded back to Q16
    localparam int CHAN_W       = 23;          // matrix output channel, signed Q16
    localparam int OUT_W        = 16;
    localparam int BITS_W       = 5;
    localparam int LIM_P_W      = 26;          // limited-range dividend
    localparam int RECIP_W      = 27;
    localparam int LIM_PROD_W   = LIM_P_W + RECIP_W;
    localparam int RECIP_SHIFT  = 35;

    localparam logic [BITS_W-1:0] BITS_MIN = 5'd8;
    localparam logic [BITS_W-1:0] BITS_MAX = 5'(SAMPLE_WIDTH);

    // ceil(2^35 / 438) and ceil(2^35 / 448): exact quotient for dividends below 2^26
    localparam logic [RECIP_W-1:0] RECIP_LUMA   = 27'd78446892;
    localparam logic [RECIP_W-1:0] RECIP_CHROMA = 27'd76695845;
    // D + 2*D*65536 with D = 219 (luma) or 224 (chroma); keeps the dividend positive
    localparam logic signed [27:0] BIAS_LUMA    = 28'sd28704987;
    localparam logic signed [27:0] BIAS_CHROMA  = 28'sd29360352;
    localparam logic signed [EXP_W-1:0] BIAS_QUOT = 20'sd65536;
    localparam logic signed [EXP_W-1:0] HALF_Q16  = 20'sd32768;

    typedef enum logic [2:0] {
        MAT_RGB    = 3'd0,
        MAT_BT709  = 3'd1,
        MAT_BT601  = 3'd2,
        MAT_BT2020 = 3'd3,
        MAT_YCGCO  = 3'd4
    } t_matrix;

    typedef enum logic [1:0] {
        REG_RANGE_MODE    = 2'd0,
        REG_SAMPLE_BITS   = 2'd1,
        REG_MATRIX_SELECT = 2'd2,
        REG_WIDE_OUTPUT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] a;   // V into R
        logic [COEF_W-1:0] b;   // U into B
        logic [COEF_W-1:0] c;   // U out of G
        logic [COEF_W-1:0] d;   // V out of G
    } t_coef;

    // Per-lane range expansion setup
    typedef struct packed {
        logic              full;    // full range
        logic              chroma;  // chroma offset and 224 scale
        logic [BITS_W-1:0] bits;    // clamped sample depth, 8..SAMPLE_WIDTH
    } t_exp_cfg;

    function automatic t_coef matrix_coef(input t_matrix mat);
        t_coef k;
        unique case (mat)
            MAT_BT709:  k = '{a: 17'd103206, b: 17'd121609, c: 17'd12276, d: 17'd30679};
            MAT_BT601:  k = '{a: 17'd91881,  b: 17'd116130, c: 17'd22553, d: 17'd46802};
            MAT_BT2020: k = '{a: 17'd96639,  b: 17'd123299, c: 17'd10784, d: 17'd37444};
            default:    k = '0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: src/ycbcr_to_rgb_pixel_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_convert
// YCbCr (or RGB) pixel to 8/16-bit RGB converter, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Throughput: one word per clock while the output does not stall; six register
//   stages (three for range expansion, matrix multiply, matrix sum, quantize),
//   each a single pass.
// Stalls back up stage by stage; bubbles are squeezed out.
// Reset (i_rst_n low, synchronous): pipeline emptied, registers take
//   limited range, 8-bit samples, BT.709, 8-bit output.
module ycbcr_to_rgb_pixel_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input pixels
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [15:0] luma, [31:16] chroma_blue, [47:32] chroma_red
    // output pixels
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [15:0] red_out, [31:16] green_out, [47:32] blue_out
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                           r_range_mode;
    logic [ycr_pkg::BITS_W-1:0]     r_sample_bits;
    logic [2:0]                     r_matrix_select;
    logic                           r_wide_output;
    logic                           cfg_wr;
    ycr_pkg::t_reg_idx              reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = ycr_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_mode    <= 1'b0;
            r_sample_bits   <= 5'd8;
            r_matrix_select <= ycr_pkg::MAT_BT709;
            r_wide_output   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ycr_pkg::REG_RANGE_MODE:    r_range_mode    <= pwdata[0];
                ycr_pkg::REG_SAMPLE_BITS:   r_sample_bits   <= pwdata[4:0];
                ycr_pkg::REG_MATRIX_SELECT: r_matrix_select <= pwdata[2:0];
                ycr_pkg::REG_WIDE_OUTPUT:   r_wide_output   <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ycr_pkg::REG_RANGE_MODE:    prdata = {31'd0, r_range_mode};
            ycr_pkg::REG_SAMPLE_BITS:   prdata = {27'd0, r_sample_bits};
            ycr_pkg::REG_MATRIX_SELECT: prdata = {29'd0, r_matrix_select};
            ycr_pkg::REG_WIDE_OUTPUT:   prdata = {31'd0, r_wide_output};
        endcase
    end

    // Effective settings: depth clamped to 8..16, unused matrix codes pass RGB
    logic [ycr_pkg::BITS_W-1:0] bits_eff;
    ycr_pkg::t_matrix           mat_eff;
    logic                       yuv;
    ycr_pkg::t_exp_cfg          cfg_luma;
    ycr_pkg::t_exp_cfg          cfg_chroma;

    always_comb begin
        priority if (r_sample_bits < ycr_pkg::BITS_MIN) bits_eff = ycr_pkg::BITS_MIN;
        else if (r_sample_bits > ycr_pkg::BITS_MAX)     bits_eff = ycr_pkg::BITS_MAX;
        else                                            bits_eff = r_sample_bits;

        if (r_matrix_select > ycr_pkg::MAT_YCGCO) begin
            mat_eff = ycr_pkg::MAT_RGB;
        end else begin
            mat_eff = ycr_pkg::t_matrix'(r_matrix_select);
        end
        yuv        = mat_eff != ycr_pkg::MAT_RGB;
        cfg_luma   = '{full: r_range_mode, chroma: 1'b0, bits: bits_eff};
        cfg_chroma = '{full: r_range_mode, chroma: yuv,  bits: bits_eff};
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] n_vld;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_s_axis_tvalid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = rdy[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Stages 0..2: range expansion, one lane per sample
    // ------------------------------------------------------------------
    logic signed [ycr_pkg::EXP_W-1:0] q_y;
    logic signed [ycr_pkg::EXP_W-1:0] q_u;
    logic signed [ycr_pkg::EXP_W-1:0] q_v;

    ycr_expand u_exp_y (
        .i_clk    (i_clk),
        .i_adv    (rdy[2:0]),
        .i_cfg    (cfg_luma),
        .i_sample (i_s_axis_tdata[15:0]),
        .o_q      (q_y)
    );

    ycr_expand u_exp_u (
        .i_clk    (i_clk),
        .i_adv    (rdy[2:0]),
        .i_cfg    (cfg_chroma),
        .i_sample (i_s_axis_tdata[31:16]),
        .o_q      (q_u)
    );

    ycr_expand u_exp_v (
        .i_clk    (i_clk),
        .i_adv    (rdy[2:0]),
        .i_cfg    (cfg_chroma),
        .i_sample (i_s_axis_tdata[47:32]),
        .o_q      (q_v)
    );

    // ------------------------------------------------------------------
    // Stage 3: coefficient products
    // ------------------------------------------------------------------
    ycr_pkg::t_coef                    coef;
    logic signed [ycr_pkg::PROD_W-1:0] r_pa;
    logic signed [ycr_pkg::PROD_W-1:0] r_pb;
    logic signed [ycr_pkg::PROD_W-1:0] r_pc;
    logic signed [ycr_pkg::PROD_W-1:0] r_pd;
    logic signed [ycr_pkg::EXP_W-1:0]  r_y3;
    logic signed [ycr_pkg::EXP_W-1:0]  r_u3;
    logic signed [ycr_pkg::EXP_W-1:0]  r_v3;

    assign coef = ycr_pkg::matrix_coef(mat_eff);

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_pa <= $signed({1'b0, coef.a}) * q_v;
            r_pb <= $signed({1'b0, coef.b}) * q_u;
            r_pc <= $signed({1'b0, coef.c}) * q_u;
            r_pd <= $signed({1'b0, coef.d}) * q_v;
            r_y3 <= q_y;
            r_u3 <= q_u;
            r_v3 <= q_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round products to Q16 (half up) and form the channels
    // ------------------------------------------------------------------
    function automatic logic signed [ycr_pkg::RND_W-1:0] rnd_q16(
        input logic signed [ycr_pkg::PROD_W-1:0] p
    );
        logic signed [ycr_pkg::PROD_W-1:0] t;
        t = p + ycr_pkg::PROD_W'(32768);
        return t[ycr_pkg::PROD_W-1:16];
    endfunction

    logic signed [ycr_pkg::CHAN_W-1:0] y_e, u_e, v_e, ra, rb, rc, rd;
    logic signed [ycr_pkg::CHAN_W-1:0] red4, grn4, blu4;
    logic signed [ycr_pkg::CHAN_W-1:0] r_red4, r_grn4, r_blu4;

    always_comb begin
        y_e = ycr_pkg::CHAN_W'(r_y3);
        u_e = ycr_pkg::CHAN_W'(r_u3);
        v_e = ycr_pkg::CHAN_W'(r_v3);
        ra  = ycr_pkg::CHAN_W'(rnd_q16(r_pa));
        rb  = ycr_pkg::CHAN_W'(rnd_q16(r_pb));
        rc  = ycr_pkg::CHAN_W'(rnd_q16(r_pc));
        rd  = ycr_pkg::CHAN_W'(rnd_q16(r_pd));
        unique case (mat_eff)
            ycr_pkg::MAT_BT709, ycr_pkg::MAT_BT601, ycr_pkg::MAT_BT2020: begin
                red4 = y_e + ra;
                grn4 = y_e - rc - rd;
                blu4 = y_e + rb;
            end
            ycr_pkg::MAT_YCGCO: begin
                red4 = y_e + u_e - v_e;
                grn4 = y_e + v_e;
                blu4 = y_e - u_e - v_e;
            end
            default: begin  // RGB pass-through
                red4 = y_e;
                grn4 = u_e;
                blu4 = v_e;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_red4 <= red4;
            r_grn4 <= grn4;
            r_blu4 <= blu4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: clip to [0, 1.0] and scale to 8 or 16 bits, half up
    // ------------------------------------------------------------------
    function automatic logic [ycr_pkg::OUT_W-1:0] quant(
        input logic signed [ycr_pkg::CHAN_W-1:0] c,
        input logic                              wide
    );
        logic [16:0] cl;
        logic [15:0] m;
        logic [33:0] t;
        if (c < 0) begin
            cl = 17'd0;
        end else if (c > 23'sd65536) begin
            cl = 17'd65536;
        end else begin
            cl = c[16:0];
        end
        m = wide ? 16'd65535 : 16'd255;
        t = 34'(cl) * 34'(m) + 34'd32768;
        return t[31:16];
    endfunction

    logic [ycr_pkg::OUT_W-1:0] r_red_out;
    logic [ycr_pkg::OUT_W-1:0] r_green_out;
    logic [ycr_pkg::OUT_W-1:0] r_blue_out;

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_red_out   <= quant(r_red4, r_wide_output);
            r_green_out <= quant(r_grn4, r_wide_output);
            r_blue_out  <= quant(r_blu4, r_wide_output);
        end
    end

    assign o_m_axis_tdata = {r_blue_out, r_green_out, r_red_out};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // full pipeline with a stalled sink must refuse new words
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while pipeline full and stalled");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted word lost at pipeline entry");

    // a stalled output holds the word behind it
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_m_axis_tready && r_vld[NSTG-1] && r_vld[NSTG-2]) |=> r_vld[NSTG-2])
        else $error("word dropped behind stalled output");

endmodule
`default_nettype wire

// File: src/ycr_expand.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_expand
// Three-stage range expansion of one sample to signed Q16.
// ----------------------------------------------------------------------------
module ycr_expand (
    input  logic                              i_clk,
    input  logic [2:0]                        i_adv,    // per-stage load enable
    input  ycr_pkg::t_exp_cfg                 i_cfg,
    input  logic [ycr_pkg::SAMPLE_WIDTH-1:0]  i_sample,
    output logic signed [ycr_pkg::EXP_W-1:0]  o_q
);

    // stage A: mask, full-range fold, limited-range dividend
    logic [16:0] mask17;
    logic [15:0] v;
    logic [4:0]  shl_full;
    logic [15:0] a_full;
    logic [15:0] a_hi;
    logic [15:0] a_lo;
    logic [3:0]  s;
    logic [4:0]  shl_lim;
    logic [16:0] off;
    logic signed [16:0] x;
    logic signed [26:0] n_lim;
    logic signed [27:0] p_lim;

    logic [ycr_pkg::LIM_P_W-1:0] r_p;
    logic [16:0]                 r_base;
    logic [16:0]                 r_rem;

    always_comb begin
        mask17   = (17'd1 << i_cfg.bits) - 17'd1;
        v        = i_sample & mask17[15:0];
        // full range: v*2^16 = (A + A_hi)*D + (A_hi + A_lo), D = 2^n-1
        shl_full = 5'd16 - i_cfg.bits;
        a_full   = v << shl_full;
        a_hi     = a_full >> i_cfg.bits;
        a_lo     = a_full & mask17[15:0];
        // limited range: (v - off*2^s) * 2^(16-s) / 219 or 224
        s        = 4'(i_cfg.bits - ycr_pkg::BITS_MIN);
        shl_lim  = 5'd16 - {1'b0, s};
        off      = i_cfg.chroma ? (17'd128 << s) : (17'd16 << s);
        x        = $signed({1'b0, v} - off);
        n_lim    = 27'(x) <<< shl_lim;
        p_lim    = (28'(n_lim) <<< 1)
                 + (i_cfg.chroma ? ycr_pkg::BIAS_CHROMA : ycr_pkg::BIAS_LUMA);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_p    <= p_lim[ycr_pkg::LIM_P_W-1:0];
            r_base <= {1'b0, a_full} + {1'b0, a_hi};
            r_rem  <= {1'b0, a_lo} + {1'b0, a_hi};
        end
    end

    // stage B: remainder correction and rounding, reciprocal multiply
    logic [15:0] d16;
    logic        c1;
    logic        c2;
    logic [16:0] rem2;
    logic [ycr_pkg::RECIP_W-1:0]    recip;
    logic [ycr_pkg::LIM_PROD_W-1:0] r_prod;
    logic [16:0]                    r_qf;

    always_comb begin
        d16   = mask17[15:0];
        c1    = r_rem >= {1'b0, d16};
        rem2  = c1 ? (r_rem - {1'b0, d16}) : r_rem;
        c2    = {rem2, 1'b0} > {2'b0, d16};   // D is odd, never a tie
        recip = i_cfg.chroma ? ycr_pkg::RECIP_CHROMA : ycr_pkg::RECIP_LUMA;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_prod <= ycr_pkg::LIM_PROD_W'(r_p) * ycr_pkg::LIM_PROD_W'(recip);
            r_qf   <= r_base + 17'(c1) + 17'(c2);
        end
    end

    // stage C: remove bias or chroma offset
    logic signed [ycr_pkg::EXP_W-1:0] q_lim;
    logic signed [ycr_pkg::EXP_W-1:0] q_full;
    logic signed [ycr_pkg::EXP_W-1:0] r_q;

    always_comb begin
        q_lim  = $signed({2'b0, r_prod[ycr_pkg::LIM_PROD_W-1:ycr_pkg::RECIP_SHIFT]})
               - ycr_pkg::BIAS_QUOT;
        q_full = $signed({3'b0, r_qf}) - (i_cfg.chroma ? ycr_pkg::HALF_Q16 : 20'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r_q <= i_cfg.full ? q_full : q_lim;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// File: tb/ycbcr_to_rgb_pixel_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_convert_tb
// Self-checking bench for the YCbCr to RGB pixel converter. Pixels are fed
// from a queue through a stream driver with random gaps, and results are
// taken by a monitor under random output stalls. Each accepted input word is
// converted by an in-bench Q16 predictor, and the monitor compares every
// output word against the oldest prediction. The run is split into phases.
// Between phases the converter is drained and all four registers are
// rewritten over the APB port. Depths and matrix codes include out-of-range
// values.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_pixel_convert_tb;

    localparam int  IDLE_LIMIT   = 2000; // cycles with no word and no register access
    localparam int  DRAIN_SLACK  = 12;   // pipeline is 6 deep
    localparam int  RAND_PHASES  = 20;
    localparam int  PHASE_PIXELS = 85;

    // Pixel words as they sit on the buses, last field in the low bits
    typedef struct packed {
        logic [15:0] chroma_red;
        logic [15:0] chroma_blue;
        logic [15:0] luma;
    } t_ycc;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // [15:0] luma, [31:16] chroma_blue, [47:32] chroma_red
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // [15:0] red_out, [31:16] green_out, [47:32] blue_out
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ycbcr_to_rgb_pixel_convert u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 i_clk = ~i_clk;

    // Register mirror, starts at the reset values
    logic       cfg_range  = 1'b0;
    logic [4:0] cfg_depth  = 5'd8;
    logic [2:0] cfg_matrix = 3'(ycr_pkg::MAT_BT709);
    logic       cfg_wide   = 1'b0;

    t_ycc pixel_q[$];       // pixels not yet driven
    t_rgb expected_rgb[$];  // predicted colors, oldest first
    int   words_left  = 0;  // queued but not yet accepted
    bit   word_taken  = 1'b0;
    int   bad_pixels  = 0;
    int   in_gap      = 0;
    int   in_calm     = 0;
    int   out_stall   = 0;
    int   out_calm    = 0;
    int   idle_cycles = 0;

    // ------------------------------------------------------------------
    // Q16 conversion model
    // ------------------------------------------------------------------
    function automatic longint div_floor(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // round half up
    function automatic longint div_round(longint num, longint den);
        return div_floor(2 * num + den, 2 * den);
    endfunction

    // depth codes below 8 act as 8, above 16 as 16
    function automatic int eff_depth();
        if (cfg_depth < 5'd8)
            return 8;
        if (cfg_depth > 5'd16)
            return 16;
        return int'(cfg_depth);
    endfunction

    function automatic longint expand_sample(longint v, int depth, bit chroma, bit full);
        longint scale;
        longint q;
        if (full) begin
            q = div_round(v * 65536, (longint'(1) << depth) - 1);
            return chroma ? q - 32768 : q;
        end
        scale = longint'(1) << (depth - 8);
        if (chroma)
            return div_round((v - 128 * scale) * 65536, 224 * scale);
        return div_round((v - 16 * scale) * 65536, 219 * scale);
    endfunction

    // Q16 product rounded half up; >>> on a signed value floors
    function automatic longint coef_mul(longint k, longint x);
        return (k * x + 32768) >>> 16;
    endfunction

    function automatic logic [15:0] quant_chan(longint c, bit wide);
        longint m;
        m = wide ? 65535 : 255;
        if (c < 0)
            c = 0;
        if (c > 65536)
            c = 65536;
        return 16'((c * m + 32768) >> 16);
    endfunction

    function automatic t_rgb convert_pixel(t_ycc p);
        int               depth;
        ycr_pkg::t_matrix mat;
        bit               yuv;
        longint           mask, y, u, v, r, g, b;
        longint           ka, kb, kc, kd;
        t_rgb             o;
        depth = eff_depth();
        // unused matrix codes fall back to pass-through
        mat   = (cfg_matrix > 3'(ycr_pkg::MAT_YCGCO)) ? ycr_pkg::MAT_RGB
                                                      : ycr_pkg::t_matrix'(cfg_matrix);
        yuv   = (mat != ycr_pkg::MAT_RGB);
        mask  = (longint'(1) << depth) - 1;
        y = expand_sample(longint'(p.luma) & mask, depth, 1'b0, cfg_range);
        u = expand_sample(longint'(p.chroma_blue) & mask, depth, yuv, cfg_range);
        v = expand_sample(longint'(p.chroma_red) & mask, depth, yuv, cfg_range);
        ka = 0; kb = 0; kc = 0; kd = 0;
        case (mat)
            ycr_pkg::MAT_BT709: begin
                ka = 103206; kb = 121609; kc = 12276; kd = 30679;
            end
            ycr_pkg::MAT_BT601: begin
                ka = 91881;  kb = 116130; kc = 22553; kd = 46802;
            end
            ycr_pkg::MAT_BT2020: begin
                ka = 96639;  kb = 123299; kc = 10784; kd = 37444;
            end
            default: ;
        endcase
        if (mat == ycr_pkg::MAT_RGB) begin
            r = y; g = u; b = v;
        end else if (mat == ycr_pkg::MAT_YCGCO) begin
            r = y + u - v;
            g = y + v;
            b = y - u - v;
        end else begin
            r = y + coef_mul(ka, v);
            b = y + coef_mul(kb, u);
            g = y - coef_mul(kc, u) - coef_mul(kd, v);
        end
        o.red   = quant_chan(r, cfg_wide);
        o.green = quant_chan(g, cfg_wide);
        o.blue  = quant_chan(b, cfg_wide);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, a few long ones, and now and then a stretch of none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            calm = $urandom_range(20, 80);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One sample: raw 16 bits, in-depth values, values near the nominal
    // black/white/chroma limits, or the depth extremes; high bits may carry junk
    function automatic logic [15:0] gen_sample();
        int          depth;
        int          pick;
        int          base;
        logic [15:0] mask;
        logic [15:0] junk;
        logic [15:0] v;
        depth = eff_depth();
        mask  = 16'((32'd1 << depth) - 1);
        junk  = 16'($urandom) & ~mask;
        pick  = $urandom_range(0, 99);
        if (pick < 40)
            return 16'($urandom);
        if (pick < 70) begin
            v = 16'($urandom) & mask;
        end else if (pick < 90) begin
            case ($urandom_range(0, 5))
                0:       base = 16;
                1:       base = 235;
                2:       base = 240;
                3:       base = 128;
                4:       base = 0;
                default: base = 255;
            endcase
            base = (base << (depth - 8)) + int'($urandom_range(0, 6)) - 3;
            if (base < 0)
                base = 0;
            if (base > int'(mask))
                base = int'(mask);
            v = 16'(base);
        end else begin
            v = $urandom_range(0, 1) ? mask : 16'd0;
        end
        if ($urandom_range(0, 1))
            v = v | junk;
        return v;
    endfunction

    task automatic send_pixel(input logic [15:0] y, input logic [15:0] cb,
                              input logic [15:0] cr);
        pixel_q.push_back('{chroma_red: cr, chroma_blue: cb, luma: y});
        words_left++;
    endtask

    // Wait until every queued word went in and every result came out
    task automatic drain();
        while (words_left != 0 || expected_rgb.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; psel is left high for the
    // caller to drop so back-to-back writes never double-drive it
    task automatic reg_write(input ycr_pkg::t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            ycr_pkg::REG_RANGE_MODE:    cfg_range  = val[0];
            ycr_pkg::REG_SAMPLE_BITS:   cfg_depth  = val[4:0];
            ycr_pkg::REG_MATRIX_SELECT: cfg_matrix = val[2:0];
            ycr_pkg::REG_WIDE_OUTPUT:   cfg_wide   = val[0];
            default: ;
        endcase
    endtask

    // Drain, then rewrite all four registers; unused upper bits get junk
    task automatic set_config(input logic rng, input logic [4:0] depth,
                              input logic [2:0] mat, input logic wide);
        drain();
        reg_write(ycr_pkg::REG_RANGE_MODE,    ($urandom & ~32'h1)  | 32'(rng));
        reg_write(ycr_pkg::REG_SAMPLE_BITS,   ($urandom & ~32'h1f) | 32'(depth));
        reg_write(ycr_pkg::REG_MATRIX_SELECT, ($urandom & ~32'h7)  | 32'(mat));
        reg_write(ycr_pkg::REG_WIDE_OUTPUT,   ($urandom & ~32'h1)  | 32'(wide));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input driver: holds a word until taken, then gap or next word
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || word_taken)) begin
            word_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                i_s_axis_tdata  <= pixel_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                in_gap = pick_gap(in_calm);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            out_stall = pick_gap(out_calm);
        end
    end

    // ------------------------------------------------------------------
    // Predict on input accept, check on output accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_rgb want;
        t_rgb got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_rgb.push_back(convert_pixel(i_s_axis_tdata));
                word_taken = 1'b1;
                words_left--;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (expected_rgb.size() == 0) begin
                    if (bad_pixels < 10)
                        $display("unexpected output word %h at %0t", got, $realtime);
                    bad_pixels++;
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        if (bad_pixels < 10)
                            $display({"pixel mismatch at %0t: exp r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        bad_pixels++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word or register access
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int         p;
        int         n;
        logic       r_range;
        logic [4:0] r_depth;
        logic [2:0] r_mat;
        logic       r_wide;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: limited 8-bit BT.709, 8-bit out
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'd16,   16'd128,  16'd128);   // black
        send_pixel(16'd235,  16'd128,  16'd128);   // white
        send_pixel(16'd235,  16'd240,  16'd240);   // clips high
        send_pixel(16'd16,   16'd16,   16'd16);    // clips low
        send_pixel(16'hab10, 16'hff80, 16'h1280);  // junk above depth, black again

        // Full 16-bit YCgCo, wide out
        set_config(1'b1, 5'd16, 3'(ycr_pkg::MAT_YCGCO), 1'b1);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'h8000, 16'h0000, 16'hffff);
        send_pixel(16'hffff, 16'h8000, 16'h8000);

        // Depth below range acts as 8, unused matrix code acts as pass-through
        set_config(1'b1, 5'd3, 3'd6, 1'b0);
        send_pixel(16'd255,  16'd0,    16'd128);
        send_pixel(16'hffff, 16'h0100, 16'h0080);

        // Depth above range acts as 16, limited BT.601
        set_config(1'b0, 5'd20, 3'(ycr_pkg::MAT_BT601), 1'b1);
        send_pixel(16'h1000, 16'h8000, 16'h8000);
        send_pixel(16'heb00, 16'h0000, 16'hffff);

        // Limited 10-bit BT.2020
        set_config(1'b0, 5'd10, 3'(ycr_pkg::MAT_BT2020), 1'b0);
        send_pixel(16'd940, 16'd64,  16'd960);
        send_pixel(16'd64,  16'd512, 16'd512);

        // Full 12-bit pass-through, wide out
        set_config(1'b1, 5'd12, 3'(ycr_pkg::MAT_RGB), 1'b1);
        send_pixel(16'd4095, 16'd0, 16'd2048);

        // Random phases; the first few pin the register extremes
        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    r_range = 1'b0; r_depth = 5'd8;  r_mat = 3'(ycr_pkg::MAT_RGB);
                    r_wide  = 1'b0;
                end
                1: begin
                    r_range = 1'b1; r_depth = 5'd16; r_mat = 3'(ycr_pkg::MAT_BT709);
                    r_wide  = 1'b1;
                end
                2: begin
                    r_range = 1'b0; r_depth = 5'd16; r_mat = 3'(ycr_pkg::MAT_YCGCO);
                    r_wide  = 1'b0;
                end
                3: begin
                    r_range = 1'b1; r_depth = 5'd31; r_mat = 3'd7;
                    r_wide  = 1'b1;
                end
                4: begin
                    r_range = 1'b0; r_depth = 5'd0;  r_mat = 3'(ycr_pkg::MAT_BT2020);
                    r_wide  = 1'b1;
                end
                default: begin
                    r_range = 1'($urandom_range(0, 1));
                    r_depth = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(8, 16))
                                                           : 5'($urandom_range(0, 31));
                    r_mat   = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                           : 3'($urandom_range(5, 7));
                    r_wide  = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(r_range, r_depth, r_mat, r_wide);
            for (n = 0; n < PHASE_PIXELS; n++)
                send_pixel(gen_sample(), gen_sample(), gen_sample());
        end

        drain();
        if (bad_pixels == 0 && expected_rgb.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
src/ycr_pkg.sv
src/ycr_expand.sv
src/ycbcr_to_rgb_pixel_convert.sv
tb/ycbcr_to_rgb_pixel_convert_tb.sv
